// ----- rtl/ioa_pkg.sv -----
// ---------------------------------------------------------------------------
// ioa_pkg : shared types and constants
// widths, scaling constants and the command format passed from the front
// end to the arithmetic back end of the oversampling averager
// ---------------------------------------------------------------------------
package ioa_pkg;

    localparam int CHANNELS = 6;
    localparam int ROUNDS   = 1000;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHF_W    = 3;
    localparam int CMP_W    = (CH_W > CHF_W) ? CH_W : CHF_W;
    localparam int SAMPLE_W = 12;
    localparam int VAL_W    = 12;
    localparam int SUM_W    = 22;
    localparam int RND_W    = 10;
    localparam int ROUNDS_W = 11;

    localparam int SCALE_MUL   = 13206;
    localparam int SCALE_SHIFT = 14;
    localparam int MV_FULL     = 3300;
    localparam int SPAN_SHIFT  = 12;

    localparam int         RECIP_SHIFT = 32;
    localparam int         RECIP_W     = 33;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / ROUNDS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = 2;

    localparam logic KIND_TRACE = 1'b0;
    localparam logic KIND_AVG   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [CHF_W-1:0] ch;
        logic [SUM_W-1:0] data;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [CHF_W-1:0] ch;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_res;

    typedef enum logic {
        FS_RUN,
        FS_DRAIN
    } t_front_state;

endpackage

// ----- rtl/interleaved_adc_oversample_average.sv -----
// ---------------------------------------------------------------------------
// interleaved_adc_oversample_average : six-channel oversampling averager
// accumulates interleaved converter samples and reports averages in mV
// ---------------------------------------------------------------------------
// usage:
// samples enter on the s_axis channel in round-robin channel order, channel
// 0 first, one item per cycle while tready is high. each sample of the
// traced channel (config register, reset value 4) comes out on m_axis as
// tuser = 0, scaled by 0.806. after the last sample of ROUNDS full rounds
// the block emits one average item per channel in channel order (tuser = 1),
// the last with tlast set, and clears the sums; that closing sample gives no
// traced item. a traced item passes the command queue and the 4-stage
// multiply pipeline into the output register; the averages follow the
// closing sample one per cycle while the receiver takes them.
// throughput: one sample per cycle while the queue has room; at frame end
// intake pauses while the front end sweeps the sums into the command queue.
// a stalled receiver freezes the pipeline; the 4-entry queue then fills and
// tready drops. reset restarts the frame at channel 0 with zero sums.
// ---------------------------------------------------------------------------
module interleaved_adc_oversample_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] sample, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [2:0] channel, [14:3] value, [15] zero
    output logic        o_m_axis_tuser,   // [0] kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    ioa_pkg::t_cmd cmd;
    ioa_pkg::t_cmd head;
    ioa_pkg::t_res res;

    ioa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_sample      (i_s_axis_tdata[ioa_pkg::SAMPLE_W-1:0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    ioa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    ioa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {1'b0, res.value, res.ch};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

// ----- rtl/ioa_front.sv -----
// ---------------------------------------------------------------------------
// ioa_front : sample intake and accumulation
// tracks channel and round, accumulates per-channel sums, issues trace
// commands and sweeps the sums out as average commands at frame end
// ---------------------------------------------------------------------------
module ioa_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ioa_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_cfg_wr_en,
    input  logic [ioa_pkg::CHF_W-1:0]       i_cfg_wr_data,
    input  logic                            i_q_full,
    output logic                            o_push,
    output ioa_pkg::t_cmd                   o_cmd
);

    logic [ioa_pkg::CH_W-1:0]   r_ch;
    logic [ioa_pkg::RND_W-1:0]  r_round;
    logic [ioa_pkg::SUM_W-1:0]  r_sum [ioa_pkg::CHANNELS];
    logic [ioa_pkg::CHF_W-1:0]  r_trace;
    logic [ioa_pkg::CH_W-1:0]   r_drain;
    ioa_pkg::t_front_state      r_state;
    ioa_pkg::t_front_state      n_state;

    logic accept;
    logic last_ch;
    logic close;
    logic match;
    logic drain_last;

    assign last_ch    = (r_ch == ioa_pkg::CH_W'(ioa_pkg::CHANNELS - 1));
    assign close      = last_ch && (r_round == ioa_pkg::RND_W'(ioa_pkg::ROUNDS - 1));
    assign match      = (ioa_pkg::CMP_W'(r_ch) == ioa_pkg::CMP_W'(r_trace));
    assign drain_last = (r_drain == ioa_pkg::CH_W'(ioa_pkg::CHANNELS - 1));
    assign accept     = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ioa_pkg::FS_RUN: begin
                if (accept && close) begin
                    n_state = ioa_pkg::FS_DRAIN;
                end
            end
            ioa_pkg::FS_DRAIN: begin
                if (!i_q_full && drain_last) begin
                    n_state = ioa_pkg::FS_RUN;
                end
            end
            default: n_state = ioa_pkg::FS_RUN;
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            ioa_pkg::FS_RUN: begin
                o_ready   = !i_q_full;
                o_push    = accept && match && !close;
                o_cmd.kind = ioa_pkg::KIND_TRACE;
                o_cmd.ch   = ioa_pkg::CHF_W'(r_ch);
                o_cmd.data = ioa_pkg::SUM_W'(i_sample);
                o_cmd.last = 1'b0;
            end
            ioa_pkg::FS_DRAIN: begin
                o_push     = !i_q_full;
                o_cmd.kind = ioa_pkg::KIND_AVG;
                o_cmd.ch   = ioa_pkg::CHF_W'(r_drain);
                o_cmd.data = r_sum[0];
                o_cmd.last = drain_last;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ioa_pkg::FS_RUN;
            r_ch    <= '0;
            r_round <= '0;
            r_trace <= ioa_pkg::CHF_W'(4);
            r_drain <= '0;
            for (int i = 0; i < ioa_pkg::CHANNELS; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_trace <= i_cfg_wr_data;
            end
            if (accept) begin
                r_sum[r_ch] <= r_sum[r_ch] + ioa_pkg::SUM_W'(i_sample);
                if (last_ch) begin
                    r_ch    <= '0;
                    r_round <= close ? '0 : r_round + 1'b1;
                end else begin
                    r_ch <= r_ch + 1'b1;
                end
            end
            // sweep: emit slot 0, shift the rest down, zeros fill in
            if (r_state == ioa_pkg::FS_DRAIN && !i_q_full) begin
                for (int i = 0; i < ioa_pkg::CHANNELS - 1; i++) begin
                    r_sum[i] <= r_sum[i+1];
                end
                r_sum[ioa_pkg::CHANNELS-1] <= '0;
                r_drain <= drain_last ? '0 : r_drain + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ioa_queue.sv -----
// ---------------------------------------------------------------------------
// ioa_queue : command queue
// short fifo between front end and back end so each side stalls alone
// ---------------------------------------------------------------------------
module ioa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ioa_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ioa_pkg::t_cmd o_head
);

    ioa_pkg::t_cmd            r_mem [ioa_pkg::QUEUE_DEPTH];
    logic [ioa_pkg::QA_W-1:0] r_wr;
    logic [ioa_pkg::QA_W-1:0] r_rd;
    logic [ioa_pkg::QA_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (ioa_pkg::QA_W+1)'(ioa_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/ioa_back.sv -----
// ---------------------------------------------------------------------------
// ioa_back : scaling and averaging pipeline
// four stages: reciprocal multiply, quotient check product, quotient fix,
// millivolt scale into the output register
// ---------------------------------------------------------------------------
module ioa_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  ioa_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output ioa_pkg::t_res o_res
);

    localparam int QP_W = ioa_pkg::SUM_W + ioa_pkg::RECIP_W;
    localparam int SP_W = ioa_pkg::SAMPLE_W + ioa_pkg::SCALE_SHIFT;
    localparam int RP_W = ioa_pkg::SUM_W + ioa_pkg::ROUNDS_W;
    localparam int MP_W = ioa_pkg::VAL_W + ioa_pkg::SPAN_SHIFT;

    logic adv;

    logic                        r_s2_v, r_s2_kind, r_s2_last;
    logic [ioa_pkg::CHF_W-1:0]   r_s2_ch;
    logic [ioa_pkg::SUM_W-1:0]   r_s2_data, r_s2_q0;
    logic [ioa_pkg::VAL_W-1:0]   r_s2_scaled;

    logic                        r_s3_v, r_s3_kind, r_s3_last;
    logic [ioa_pkg::CHF_W-1:0]   r_s3_ch;
    logic [ioa_pkg::SUM_W-1:0]   r_s3_data, r_s3_q0, r_s3_prod;
    logic [ioa_pkg::VAL_W-1:0]   r_s3_scaled;

    logic                        r_s4_v, r_s4_kind, r_s4_last;
    logic [ioa_pkg::CHF_W-1:0]   r_s4_ch;
    logic [ioa_pkg::VAL_W-1:0]   r_s4_val;

    logic                        r_ov;
    ioa_pkg::t_res               r_res;

    logic [QP_W-1:0]             qprod;
    logic [SP_W-1:0]             sprod;
    logic [RP_W-1:0]             rprod;
    logic [ioa_pkg::SUM_W-1:0]   rem;
    logic [ioa_pkg::SUM_W-1:0]   q_fix;
    logic [MP_W-1:0]             mprod;

    assign adv     = !r_ov || i_ready;
    assign o_pop   = adv && !i_q_empty;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    assign qprod = QP_W'(i_head.data) * QP_W'(ioa_pkg::RECIP);
    assign sprod = SP_W'(i_head.data[ioa_pkg::SAMPLE_W-1:0]) * SP_W'(ioa_pkg::SCALE_MUL);
    assign rprod = RP_W'(r_s2_q0) * RP_W'(ioa_pkg::ROUNDS);
    assign rem   = r_s3_data - r_s3_prod;
    assign q_fix = (rem >= ioa_pkg::SUM_W'(ioa_pkg::ROUNDS)) ? r_s3_q0 + 1'b1 : r_s3_q0;
    assign mprod = MP_W'(r_s4_val) * MP_W'(ioa_pkg::MV_FULL);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_kind   <= i_head.kind;
            r_s2_ch     <= i_head.ch;
            r_s2_last   <= i_head.last;
            r_s2_data   <= i_head.data;
            r_s2_q0     <= qprod[ioa_pkg::RECIP_SHIFT +: ioa_pkg::SUM_W];
            r_s2_scaled <= sprod[ioa_pkg::SCALE_SHIFT +: ioa_pkg::VAL_W];

            r_s3_kind   <= r_s2_kind;
            r_s3_ch     <= r_s2_ch;
            r_s3_last   <= r_s2_last;
            r_s3_data   <= r_s2_data;
            r_s3_q0     <= r_s2_q0;
            r_s3_prod   <= rprod[ioa_pkg::SUM_W-1:0];
            r_s3_scaled <= r_s2_scaled;

            r_s4_kind   <= r_s3_kind;
            r_s4_ch     <= r_s3_ch;
            r_s4_last   <= r_s3_last;
            r_s4_val    <= (r_s3_kind == ioa_pkg::KIND_AVG) ? q_fix[ioa_pkg::VAL_W-1:0]
                                                            : r_s3_scaled;

            r_res.kind  <= r_s4_kind;
            r_res.ch    <= r_s4_ch;
            r_res.last  <= r_s4_last;
            r_res.value <= (r_s4_kind == ioa_pkg::KIND_AVG)
                           ? mprod[ioa_pkg::SPAN_SHIFT +: ioa_pkg::VAL_W] : r_s4_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (adv) begin
            r_s2_v <= !i_q_empty;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_ov   <= r_s4_v;
        end
    end

endmodule

// ----- rtl/ioa_checker.sv -----
// ---------------------------------------------------------------------------
// ioa_checker : port-level checks
// output framing and value range of the averager, bound to the top level
// ---------------------------------------------------------------------------
module ioa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata,
    input  logic        o_m_axis_tuser,
    input  logic        o_m_axis_tlast
);

    a_last_is_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser == ioa_pkg::KIND_AVG)
        else $error("tlast on a traced item");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast
        |-> o_m_axis_tdata[2:0] == 3'(ioa_pkg::CHANNELS - 1))
        else $error("tlast not on final channel");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[14:3] <= 12'(ioa_pkg::MV_FULL)
                            && o_m_axis_tdata[15] == 1'b0)
        else $error("output value out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed under stall");

endmodule

bind interleaved_adc_oversample_average ioa_checker u_ioa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- verif/interleaved_adc_oversample_average_tb.sv -----
// ---------------------------------------------------------------------------
// interleaved_adc_oversample_average_tb : averager stream check
// feeds interleaved samples with random gaps and back-pressure, predicts the
// scaled traced samples and per-frame channel averages, and compares every
// output item field by field in order
// ---------------------------------------------------------------------------
module interleaved_adc_oversample_average_tb;

    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_ZERO
    } t_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;     // [11:0] sample, [15:12] zero
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;          // [2:0] channel, [14:3] value, [15] zero
    logic        o_m_axis_tuser;          // [0] kind
    logic        o_m_axis_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_wr_data = '0;

    interleaved_adc_oversample_average dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // averager state mirror
    logic [2:0]                trace_reg = 3'd4;
    logic [ioa_pkg::SUM_W-1:0] chan_sums [ioa_pkg::CHANNELS];
    int unsigned               next_chan = 0;
    int unsigned               rounds_done = 0;
    ioa_pkg::t_res             expected_q [$];

    logic [11:0] sample_q [$];
    int          gap_left = 0;
    int          stall_left = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    int          errors = 0;
    int          samples_taken = 0;
    int          traced_seen = 0;
    int          averages_seen = 0;
    int          pushed = 0;

    initial begin
        foreach (chan_sums[i]) chan_sums[i] = '0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic accumulate_sample(input logic [11:0] s);
        int unsigned   c;
        int unsigned   avg;
        int unsigned   mv;
        bit            frame_end;
        ioa_pkg::t_res r;
        c = next_chan;
        chan_sums[c] += ioa_pkg::SUM_W'(s);
        frame_end = 1'b0;
        if (c == ioa_pkg::CHANNELS - 1) begin
            next_chan = 0;
            if (rounds_done == ioa_pkg::ROUNDS - 1) begin
                frame_end = 1'b1;
                rounds_done = 0;
            end else begin
                rounds_done++;
            end
        end else begin
            next_chan = c + 1;
        end
        if (frame_end) begin
            for (int i = 0; i < ioa_pkg::CHANNELS; i++) begin
                avg = int'(chan_sums[i]) / ioa_pkg::ROUNDS;
                mv = (avg * ioa_pkg::MV_FULL) >> ioa_pkg::SPAN_SHIFT;
                r.kind = ioa_pkg::KIND_AVG;
                r.ch = ioa_pkg::CHF_W'(i);
                r.value = ioa_pkg::VAL_W'(mv);
                r.last = (i == ioa_pkg::CHANNELS - 1);
                expected_q.push_back(r);
                chan_sums[i] = '0;
            end
        end else if (c == trace_reg) begin
            r.kind = ioa_pkg::KIND_TRACE;
            r.ch = ioa_pkg::CHF_W'(c);
            r.value = ioa_pkg::VAL_W'((int'(s) * ioa_pkg::SCALE_MUL) >> ioa_pkg::SCALE_SHIFT);
            r.last = 1'b0;
            expected_q.push_back(r);
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        bit slot_free;
        bit launch;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            launch = 1'b0;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                accumulate_sample(i_s_axis_tdata[11:0]);
                samples_taken++;
                gap_left = tx_idle ? pick_gap() : 0;
            end
            slot_free = !i_s_axis_tvalid || o_s_axis_tready;
            if (slot_free) begin
                if (gap_left > 0) gap_left--;
                else if (sample_q.size() > 0) launch = 1'b1;
            end
            if (launch) begin
                i_s_axis_tdata <= {4'b0, sample_q.pop_front()};
                i_s_axis_tvalid <= 1'b1;
            end else if (slot_free) begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (rx_idle && $urandom_range(0, 99) < 25) stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input logic [15:0] got);
        if (got !== 16'(want)) begin
            errors++;
            if (errors <= 100)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        ioa_pkg::t_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: item with nothing expected, expected none, got tdata %h",
                             $time, o_m_axis_tdata);
            end else begin
                want = expected_q.pop_front();
                check_field("kind", want.kind, o_m_axis_tuser);
                check_field("channel", want.ch, o_m_axis_tdata[2:0]);
                check_field("value", want.value, o_m_axis_tdata[14:3]);
                check_field("last", want.last, o_m_axis_tlast);
                if (want.kind == ioa_pkg::KIND_AVG) averages_seen++;
                else traced_seen++;
            end
        end
    end

    function automatic logic [11:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'(1 << $urandom_range(0, 11));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_s_axis_tvalid || expected_q.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_trace(input logic [2:0] t);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= t;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        trace_reg = t;
    endtask

    task automatic run_phase(input int n, input t_fill fill, input bit tx_gaps,
                             input bit rx_gaps);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_MAX:  sample_q.push_back(12'hFFF);
                FILL_ZERO: sample_q.push_back(12'h000);
                default:   sample_q.push_back(rand_sample());
            endcase
        end
        pushed += n;
        wait_idle();
    endtask

    initial begin
        logic [11:0] directed [24];
        logic [2:0]  trace_order [8];
        directed = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF, 12'h001,
                     12'h800, 12'h7FF, 12'h000, 12'hFFF, 12'h000, 12'hFFE,
                     12'h123, 12'hFED, 12'h400, 12'hBFF, 12'h800, 12'h3FF,
                     12'h001, 12'h002, 12'h004, 12'h008, 12'h001, 12'hF00};
        trace_order = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd3, 3'd5, 3'd4};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset trace setting, back to back
        foreach (directed[i]) sample_q.push_back(directed[i]);
        pushed += 24;
        wait_idle();

        // every trace setting, including the two that never match
        foreach (trace_order[i]) begin
            write_trace(trace_order[i]);
            run_phase(30, FILL_RANDOM, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
        end

        // full-scale and all-zero runs, then a short random tail
        write_trace(3'd5);
        run_phase(24, FILL_MAX, 1'b1, 1'b0);
        write_trace(3'd2);
        run_phase(24, FILL_ZERO, 1'b0, 1'b1);
        write_trace(3'd3);
        run_phase(8, FILL_RANDOM, 1'b1, 1'b1);

        for (int i = 0; i < 50000 && expected_q.size() != 0; i++) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (expected_q.size() != 0) begin
            errors++;
            $display("%0t: results missing, expected %0d more, got 0",
                     $time, expected_q.size());
        end

        $display("sent %0d samples over all eight trace settings with random gaps and stalls",
                 samples_taken);
        $display("checked %0d traced values and %0d channel averages",
                 traced_seen, averages_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ioa_pkg.sv
rtl/ioa_front.sv
rtl/ioa_queue.sv
rtl/ioa_back.sv
rtl/interleaved_adc_oversample_average.sv
rtl/ioa_checker.sv
verif/interleaved_adc_oversample_average_tb.sv
